// ===== sv/ekt_pkg.sv =====
// Package for the exact-match key table: status and op codes, field widths
// and the flag struct passed from the key array to the top level.
// No dependencies.
`default_nettype none

package ekt_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned IdW     = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned KeyLenW = 3;
  localparam int unsigned InWords = 4;

  localparam logic [KeyLenW-1:0] KeyLenReset = 3'd4;

  typedef enum logic [2:0] {
    StNew     = 3'd0,
    StUpdated = 3'd1,
    StFull    = 3'd2,
    StHit     = 3'd3,
    StMiss    = 3'd4
  } status_e;

  typedef enum logic {
    OpInsert = 1'b0,
    OpLookup = 1'b1
  } op_e;

  // Key array status for the item under compare
  typedef struct packed {
    logic hit;
    logic free;
  } cam_flags_t;

endpackage

`default_nettype wire

// ===== sv/ekt_in_if.sv =====
// Input channel of the exact-match key table: valid/ready plus one request word.
// Depends on ekt_pkg.
`default_nettype none

interface ekt_in_if;
  logic                          valid;
  logic                          ready;
  ekt_pkg::op_e                  op;
  logic [ekt_pkg::IdW-1:0]       entry_id;
  logic [ekt_pkg::WordW-1:0]     key_word_0;
  logic [ekt_pkg::WordW-1:0]     key_word_1;
  logic [ekt_pkg::WordW-1:0]     key_word_2;
  logic [ekt_pkg::WordW-1:0]     key_word_3;

  modport source (
    output valid, op, entry_id, key_word_0, key_word_1, key_word_2, key_word_3,
    input  ready
  );
  modport sink (
    input  valid, op, entry_id, key_word_0, key_word_1, key_word_2, key_word_3,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/ekt_out_if.sv =====
// Result channel of the exact-match key table: valid/ready plus one result word.
// Depends on ekt_pkg.
`default_nettype none

interface ekt_out_if;
  logic                        valid;
  logic                        ready;
  ekt_pkg::status_e            status;
  logic [ekt_pkg::IdW-1:0]     found_id;
  logic [ekt_pkg::CountW-1:0]  hit_count;
  logic [ekt_pkg::CountW-1:0]  miss_count;

  modport source (
    output valid, status, found_id, hit_count, miss_count,
    input  ready
  );
  modport sink (
    input  valid, status, found_id, hit_count, miss_count,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/ekt_cfg_if.sv =====
// Configuration write channel of the exact-match key table (key length).
// Depends on ekt_pkg.
`default_nettype none

interface ekt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ekt_pkg::KeyLenW-1:0]   key_length;

  modport source (output valid, key_length, input ready);
  modport sink   (input valid, key_length, output ready);
endinterface

`default_nettype wire

// ===== sv/ekt_cam.sv =====
// Key array of the exact-match key table: stored keys and valid bits, parallel
// compare of every slot, lowest-match and lowest-free priority encoders.
// Depends on ekt_pkg.
`default_nettype none

module ekt_cam #(
  parameter int unsigned TableEntries = 64,
  parameter int unsigned KeyWords     = 4
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic [KeyWords-1:0][ekt_pkg::WordW-1:0]     key_i,
  input  logic [ekt_pkg::KeyLenW-1:0]                 key_length_i,
  input  logic                                        wr_i,
  input  logic [$clog2(TableEntries)-1:0]             wr_idx_i,
  output ekt_pkg::cam_flags_t                         flags_o,
  output logic [$clog2(TableEntries)-1:0]             match_idx_o,
  output logic [$clog2(TableEntries)-1:0]             free_idx_o
);
  import ekt_pkg::*;

  localparam int unsigned IdxW = $clog2(TableEntries);

  logic [TableEntries-1:0]             valid_q;
  logic [KeyWords-1:0][WordW-1:0]      key_q [TableEntries];
  logic [KeyWords-1:0]                 word_en;
  logic [TableEntries-1:0]             match;
  logic [TableEntries-1:0]             match_first;
  logic [TableEntries-1:0]             free_first;

  // Word 0 always takes part; word w only while key_length exceeds w
  always_comb begin
    for (int w = 0; w < int'(KeyWords); w++) begin
      word_en[w] = (w == 0) || (int'(key_length_i) > w);
    end
  end

  for (genvar s = 0; s < TableEntries; s++) begin : g_row
    logic [KeyWords-1:0] word_ok;
    for (genvar w = 0; w < KeyWords; w++) begin : g_word
      assign word_ok[w] = !word_en[w] || (key_q[s][w] == key_i[w]);
    end
    assign match[s] = valid_q[s] && (&word_ok);
  end

  // Isolate lowest set bit
  assign match_first = match & (~match + TableEntries'(1));
  assign free_first  = ~valid_q & (valid_q + TableEntries'(1));

  always_comb begin
    match_idx_o = '0;
    free_idx_o  = '0;
    for (int i = 0; i < int'(TableEntries); i++) begin
      if (match_first[i]) match_idx_o = match_idx_o | IdxW'(i);
      if (free_first[i])  free_idx_o  = free_idx_o | IdxW'(i);
    end
  end

  assign flags_o.hit  = |match;
  assign flags_o.free = ~(&valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i) begin
      valid_q[wr_idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      key_q[wr_idx_i] <= key_i;
    end
  end

  a_wr_only_new_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> (!flags_o.hit && flags_o.free && !valid_q[wr_idx_i]))
    else $error("key write to a taken slot or for a stored key");
  a_wr_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |=> valid_q[$past(wr_idx_i)])
    else $error("written slot not marked valid");
  a_match_first_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_first) && (flags_o.hit == $onehot(match_first)))
    else $error("match priority encoder broken");

endmodule

`default_nettype wire

// ===== sv/ekt_id_ram.sv =====
// Id store of the exact-match key table: one write port, one registered read.
// No dependencies.
`default_nettype none

module ekt_id_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 16
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [$clog2(Depth)-1:0]  waddr_i,
  input  logic [Width-1:0]          wdata_i,
  input  logic                      re_i,
  input  logic [$clog2(Depth)-1:0]  raddr_i,
  output logic [Width-1:0]          rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/exact_match_key_table_unit.sv =====
// Top level of the exact-match key table: input register, counters, result
// register. Depends on ekt_pkg, ekt_in_if, ekt_out_if, ekt_cfg_if, ekt_cam, ekt_id_ram.
`default_nettype none

// Exact-match table of TABLE_ENTRIES keys of up to KEY_WORDS 16-bit words,
// each with a 16-bit id. An insert updates the id of a stored key or places
// the key in the lowest free slot (status full when none is left); a lookup
// returns hit with the id or miss and advances saturating hit/miss counters.
// Only the first key_length words are compared (0 counts as 1, values above
// KEY_WORDS as KEY_WORDS). One word is taken every cycle while the result side
// keeps up; a request is held in the input register, and its result is loaded
// into the result register, with the id read through the registered port of the
// id store, once the result side can take it; every slot is compared in parallel.
// No clearing pass after reset.
module exact_match_key_table_unit #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned KEY_WORDS     = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ekt_cfg_if.sink    cfg_i,
  ekt_in_if.sink     in_i,
  ekt_out_if.source  out_o
);
  import ekt_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  logic [KeyLenW-1:0]                 key_len_q;

  logic                               item_valid_q;
  op_e                                item_op_q;
  logic [IdW-1:0]                     item_id_q;
  logic [KEY_WORDS-1:0][WordW-1:0]    item_key_q;
  logic [KEY_WORDS-1:0][WordW-1:0]    item_key_d;
  logic [InWords-1:0][WordW-1:0]      in_words;

  logic [CountW-1:0]                  hits_q, hits_d;
  logic [CountW-1:0]                  misses_q, misses_d;

  logic                               out_valid_q;
  status_e                            out_status_q, status_d;
  logic [CountW-1:0]                  out_hits_q;
  logic [CountW-1:0]                  out_misses_q;

  cam_flags_t                         flags;
  logic [IdxW-1:0]                    match_idx;
  logic [IdxW-1:0]                    free_idx;
  logic                               cam_wr;
  logic                               ram_we;
  logic                               ram_re;
  logic [IdxW-1:0]                    ram_waddr;
  logic [IdW-1:0]                     ram_rdata;

  logic                               accept;
  logic                               advance;

  assign advance   = item_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || advance;
  assign accept    = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign in_words = {in_i.key_word_3, in_i.key_word_2, in_i.key_word_1, in_i.key_word_0};

  // Words past the fourth input word are zero
  for (genvar w = 0; w < KEY_WORDS; w++) begin : g_key
    assign item_key_d[w] = (w < InWords) ? in_words[w % InWords] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= KeyLenReset;
    end else if (cfg_i.valid) begin
      key_len_q <= cfg_i.key_length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (accept) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_op_q  <= in_i.op;
      item_id_q  <= in_i.entry_id;
      item_key_q <= item_key_d;
    end
  end

  ekt_cam #(
    .TableEntries (TABLE_ENTRIES),
    .KeyWords     (KEY_WORDS)
  ) u_cam (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (item_key_q),
    .key_length_i (key_len_q),
    .wr_i         (cam_wr),
    .wr_idx_i     (free_idx),
    .flags_o      (flags),
    .match_idx_o  (match_idx),
    .free_idx_o   (free_idx)
  );

  always_comb begin
    status_d  = StMiss;
    hits_d    = hits_q;
    misses_d  = misses_q;
    cam_wr    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = match_idx;
    if (item_op_q == OpLookup) begin
      if (flags.hit) begin
        status_d = StHit;
        if (hits_q != '1) hits_d = hits_q + CountW'(1);
      end else begin
        status_d = StMiss;
        if (misses_q != '1) misses_d = misses_q + CountW'(1);
      end
    end else if (flags.hit) begin
      status_d = StUpdated;
      ram_we   = advance;
    end else if (flags.free) begin
      status_d  = StNew;
      cam_wr    = advance;
      ram_we    = advance;
      ram_waddr = free_idx;
    end else begin
      status_d = StFull;
    end
  end

  assign ram_re = advance && (item_op_q == OpLookup);

  ekt_id_ram #(
    .Depth (TABLE_ENTRIES),
    .Width (IdW)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (item_id_q),
    .re_i    (ram_re),
    .raddr_i (match_idx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
    end else if (advance) begin
      hits_q   <= hits_d;
      misses_q <= misses_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold result while the sink stalls
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_status_q <= status_d;
      out_hits_q   <= hits_d;
      out_misses_q <= misses_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.found_id   = (out_status_q == StHit) ? ram_rdata : '0;
  assign out_o.hit_count  = out_hits_q;
  assign out_o.miss_count = out_misses_q;

  a_hits_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (hits_q >= $past(hits_q)) && (misses_q >= $past(misses_q)))
    else $error("lookup counter went backwards");
  a_lookup_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_op_q == OpLookup) |=>
      (out_status_q == StHit || out_status_q == StMiss))
    else $error("lookup produced an insert status");
  a_ram_port_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re) && (!cam_wr || ram_we))
    else $error("id store read and write collide or key written without id");

endmodule

`default_nettype wire
